### hw/rtl/ilu_pkg.sv
`default_nettype none

package ilu_pkg;

  localparam int unsigned MaxDim = 64;
  localparam int unsigned IdxW = 6;
  localparam int unsigned CntW = 13;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_ENTRY  = 2'd1,
    OP_END    = 2'd2,
    OP_FINISH = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_U     = 2'd0,
    KIND_L     = 2'd1,
    KIND_TOTAL = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_FILL = 2'd0,
    CFG_ROWS = 2'd1,
    CFG_COLS = 2'd2,
    CFG_NONE = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_BEG_WR,
    S_ENT_LAST,
    S_ENT_SEG,
    S_ENT_UPD,
    S_U_FIND,
    S_U_EMIT,
    S_L_EMIT,
    S_CLOSE,
    S_FINISH
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_BEGIN_NEW,
    CMD_BEGIN_RD,
    CMD_BEGIN_OLD,
    CMD_ENT_ID,
    CMD_ENT_LAST,
    CMD_ENT_SEG,
    CMD_ENT_UPD,
    CMD_ENT_L,
    CMD_END_START,
    CMD_U_RD,
    CMD_U_EMIT,
    CMD_L_EMIT,
    CMD_CLOSE,
    CMD_FINISH
  } cmd_e;

  typedef struct packed {
    op_e  op;
    logic fill_err;
    logic begin_ok;
    logic begin_new;
    logic col_open;
    logic row_ok;
    logic row_u;
    logic u_any;
    logic l_any;
    logic l_phase;
    logic out_free;
  } status_t;

  function automatic logic [IdxW-1:0] lowest_set(input logic [MaxDim-1:0] v);
    logic [IdxW-1:0] r;
    r = '0;
    for (int i = MaxDim - 1; i >= 0; i--) begin
      if (v[i]) r = IdxW'(i);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ilu_if.sv
`default_nettype none

interface ilu_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic       starts_supernode;
  logic [5:0] row_index;
  modport source (output valid, operation, starts_supernode, row_index, input ready);
  modport sink (input valid, operation, starts_supernode, row_index, output ready);
endinterface

interface ilu_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [5:0]  index_value;
  logic [11:0] position;
  logic        last_of_run;
  logic [12:0] skeleton_l;
  logic [12:0] skeleton_u;
  logic [12:0] nonzeros_l;
  logic [12:0] nonzeros_u;
  logic [13:0] nonzeros_lu;
  modport source (output valid, kind, index_value, position, last_of_run, skeleton_l,
                  skeleton_u, nonzeros_l, nonzeros_u, nonzeros_lu, input ready);
  modport sink (input valid, kind, index_value, position, last_of_run, skeleton_l,
                skeleton_u, nonzeros_l, nonzeros_u, nonzeros_lu, output ready);
endinterface

interface ilu_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [6:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/ilu_ctrl.sv
`default_nettype none

module ilu_ctrl
  import ilu_pkg::*;
(
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     accept_i,
  input  status_t status_i,
  output logic    in_ready_o,
  output cmd_e    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_d = S_IDLE;
        if (status_i.op == OP_FINISH) begin
          state_d = S_FINISH;
        end else if (!status_i.fill_err) begin
          case (status_i.op)
            OP_BEGIN: begin
              if (status_i.begin_ok && !status_i.begin_new) state_d = S_BEG_WR;
            end
            OP_ENTRY: begin
              if (status_i.col_open && status_i.row_ok && status_i.row_u) begin
                state_d = S_ENT_LAST;
              end
            end
            OP_END: begin
              if (status_i.col_open) state_d = S_U_FIND;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_BEG_WR:   state_d = S_IDLE;
      S_ENT_LAST: state_d = S_ENT_SEG;
      S_ENT_SEG:  state_d = S_ENT_UPD;
      S_ENT_UPD:  state_d = S_IDLE;
      S_U_FIND: begin
        if (status_i.u_any) state_d = S_U_EMIT;
        else if (status_i.l_phase) state_d = S_L_EMIT;
        else state_d = S_CLOSE;
      end
      S_U_EMIT: begin
        if (status_i.out_free) state_d = S_U_FIND;
      end
      S_L_EMIT: begin
        if (!status_i.l_any) state_d = S_CLOSE;
      end
      S_CLOSE: state_d = S_IDLE;
      S_FINISH: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_DISPATCH: begin
        if (status_i.op != OP_FINISH && !status_i.fill_err) begin
          case (status_i.op)
            OP_BEGIN: begin
              if (status_i.begin_ok) begin
                cmd_o = status_i.begin_new ? CMD_BEGIN_NEW : CMD_BEGIN_RD;
              end
            end
            OP_ENTRY: begin
              if (status_i.col_open && status_i.row_ok) begin
                cmd_o = status_i.row_u ? CMD_ENT_ID : CMD_ENT_L;
              end
            end
            OP_END: begin
              if (status_i.col_open) cmd_o = CMD_END_START;
            end
            default: cmd_o = CMD_NONE;
          endcase
        end
      end
      S_BEG_WR:   cmd_o = CMD_BEGIN_OLD;
      S_ENT_LAST: cmd_o = CMD_ENT_LAST;
      S_ENT_SEG:  cmd_o = CMD_ENT_SEG;
      S_ENT_UPD:  cmd_o = CMD_ENT_UPD;
      S_U_FIND: begin
        if (status_i.u_any) cmd_o = CMD_U_RD;
      end
      S_U_EMIT: begin
        if (status_i.out_free) cmd_o = CMD_U_EMIT;
      end
      S_L_EMIT: begin
        if (status_i.l_any && status_i.out_free) cmd_o = CMD_L_EMIT;
      end
      S_CLOSE: cmd_o = CMD_CLOSE;
      S_FINISH: begin
        if (status_i.out_free) cmd_o = CMD_FINISH;
      end
      default: cmd_o = CMD_NONE;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/ilu_dp.sv
`default_nettype none

module ilu_dp
  import ilu_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          accept_i,
  input  wire [1:0]    op_i,
  input  wire          starts_i,
  input  wire [5:0]    row_i,
  input  wire          cfg_we_i,
  input  wire [1:0]    cfg_index_i,
  input  wire [6:0]    cfg_data_i,
  input  cmd_e         cmd_i,
  output status_t      status_o,
  input  wire          out_ready_i,
  output logic         out_valid_o,
  output logic [1:0]   kind_o,
  output logic [5:0]   index_value_o,
  output logic [11:0]  position_o,
  output logic         last_of_run_o,
  output logic [12:0]  skeleton_l_o,
  output logic [12:0]  skeleton_u_o,
  output logic [12:0]  nonzeros_l_o,
  output logic [12:0]  nonzeros_u_o,
  output logic [13:0]  nonzeros_lu_o
);

  logic [3:0] fill_q;
  logic [6:0] rows_q, cols_q;
  logic [1:0] op_q;
  logic       starts_q;
  logic [5:0] row_q;

  logic [MaxDim-1:0] u_bm_q, l_bm_q;
  logic [IdxW-1:0]   cur_q, start_q, snc_q, rep_q, uidx_q;
  logic [6:0]        lcount_q, lrun_q, closed_q;
  logic              open_q;
  logic [CntW-1:0]   skl_q, sku_q, nnl_q, nnu_q;

  logic [IdxW-1:0] id_mem [MaxDim];
  logic [IdxW-1:0] last_mem [MaxDim];
  logic [IdxW-1:0] seg_mem [MaxDim];
  logic [IdxW-1:0] rd_id_q, rd_last_q, rd_seg_q;

  logic        out_valid_q, last_q;
  logic [1:0]  kind_q;
  logic [5:0]  idx_q;
  logic [11:0] pos_q;
  logic [12:0] tskl_q, tsku_q, tnnl_q, tnnu_q;
  logic [13:0] tlu_q;

  logic [6:0]        ncols, mn, closed_inc;
  logic              out_free, l_phase;
  logic [IdxW-1:0]   u_low, l_low;
  logic [MaxDim-1:0] u_rest, l_rest;
  logic [6:0]        u_len;
  logic [13:0]       nz_sum;

  assign ncols = (cols_q > 7'(MaxDim)) ? 7'(MaxDim) : cols_q;
  assign mn = (rows_q < cols_q) ? rows_q : cols_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign l_phase = (cur_q == start_q);
  assign u_low = lowest_set(u_bm_q);
  assign l_low = lowest_set(l_bm_q);
  assign u_rest = u_bm_q & ~(MaxDim'(1) << uidx_q);
  assign l_rest = l_bm_q & ~(MaxDim'(1) << l_low);
  assign u_len = (uidx_q >= rd_seg_q) ? (7'(uidx_q) - 7'(rd_seg_q) + 7'd1) : 7'd0;
  assign nz_sum = 14'(nnl_q) + 14'(nnu_q);
  assign closed_inc = closed_q + 7'd1;

  always_comb begin
    status_o.op        = op_e'(op_q);
    status_o.fill_err  = (fill_q != 4'd0);
    status_o.begin_ok  = !open_q && (closed_q < ncols);
    status_o.begin_new = (closed_q == 7'd0) || starts_q;
    status_o.col_open  = open_q;
    status_o.row_ok    = ({1'b0, row_q} < rows_q);
    status_o.row_u     = (row_q < start_q);
    status_o.u_any     = (u_bm_q != '0);
    status_o.l_any     = (l_bm_q != '0);
    status_o.l_phase   = l_phase;
    status_o.out_free  = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      rows_q <= 7'(MaxDim);
      cols_q <= 7'(MaxDim);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FILL: fill_q <= cfg_data_i[3:0];
        CFG_ROWS: rows_q <= cfg_data_i;
        CFG_COLS: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      op_q     <= op_i;
      starts_q <= starts_i;
      row_q    <= row_i;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_BEGIN_NEW: begin
        id_mem[closed_q[5:0]] <= snc_q;
        last_mem[snc_q] <= closed_q[5:0];
      end
      CMD_BEGIN_OLD: begin
        id_mem[closed_q[5:0]] <= rd_id_q;
        last_mem[rd_id_q] <= closed_q[5:0];
      end
      CMD_BEGIN_RD: rd_id_q <= id_mem[closed_q[5:0] - 6'd1];
      CMD_ENT_ID:   rd_id_q <= id_mem[row_q];
      CMD_ENT_LAST: rd_last_q <= last_mem[rd_id_q];
      CMD_ENT_SEG:  rd_seg_q <= seg_mem[rd_last_q];
      CMD_U_RD:     rd_seg_q <= seg_mem[u_low];
      CMD_ENT_UPD: begin
        if (!u_bm_q[rep_q] || (row_q < rd_seg_q)) seg_mem[rep_q] <= row_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_ENT_SEG) rep_q <= rd_last_q;
    if (cmd_i == CMD_U_RD) uidx_q <= u_low;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_bm_q <= '0;
      l_bm_q <= '0;
      cur_q <= '0;
      start_q <= '0;
      snc_q <= '0;
      lcount_q <= '0;
      lrun_q <= '0;
      closed_q <= '0;
      open_q <= 1'b0;
      skl_q <= '0;
      sku_q <= '0;
      nnl_q <= '0;
      nnu_q <= '0;
    end else begin
      case (cmd_i)
        CMD_BEGIN_NEW: begin
          snc_q <= snc_q + 6'd1;
          start_q <= closed_q[5:0];
          lcount_q <= '0;
          cur_q <= closed_q[5:0];
          open_q <= 1'b1;
        end
        CMD_BEGIN_OLD: begin
          nnl_q <= nnl_q + 13'(lcount_q);
          cur_q <= closed_q[5:0];
          open_q <= 1'b1;
        end
        CMD_ENT_UPD: u_bm_q[rep_q] <= 1'b1;
        CMD_ENT_L: begin
          if (l_phase) l_bm_q[row_q] <= 1'b1;
        end
        CMD_END_START: lrun_q <= '0;
        CMD_U_EMIT: begin
          sku_q <= sku_q + 13'd1;
          nnu_q <= nnu_q + 13'(u_len);
          u_bm_q[uidx_q] <= 1'b0;
        end
        CMD_L_EMIT: begin
          skl_q <= skl_q + 13'd1;
          lrun_q <= lrun_q + 7'd1;
          l_bm_q[l_low] <= 1'b0;
        end
        CMD_CLOSE: begin
          if (l_phase) begin
            lcount_q <= lrun_q;
            nnl_q <= nnl_q + 13'(lrun_q);
          end
          l_bm_q <= '0;
          open_q <= 1'b0;
          closed_q <= closed_inc;
          cur_q <= closed_inc[5:0];
        end
        CMD_FINISH: begin
          u_bm_q <= '0;
          l_bm_q <= '0;
          cur_q <= '0;
          start_q <= '0;
          snc_q <= '0;
          lcount_q <= '0;
          closed_q <= '0;
          open_q <= 1'b0;
          skl_q <= '0;
          sku_q <= '0;
          nnl_q <= '0;
          nnu_q <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i == CMD_U_EMIT || cmd_i == CMD_L_EMIT || cmd_i == CMD_FINISH) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_U_EMIT, CMD_L_EMIT, CMD_FINISH: begin
        kind_q <= KIND_U;
        idx_q <= '0;
        pos_q <= '0;
        last_q <= 1'b1;
        tskl_q <= '0;
        tsku_q <= '0;
        tnnl_q <= '0;
        tnnu_q <= '0;
        tlu_q <= '0;
        if (cmd_i == CMD_U_EMIT) begin
          idx_q <= rd_seg_q;
          pos_q <= sku_q[11:0];
          last_q <= (u_rest == '0) && !(l_phase && (l_bm_q != '0));
        end else if (cmd_i == CMD_L_EMIT) begin
          kind_q <= KIND_L;
          idx_q <= l_low;
          pos_q <= skl_q[11:0];
          last_q <= (l_rest == '0);
        end else if (fill_q != 4'd0) begin
          kind_q <= KIND_ERROR;
        end else begin
          kind_q <= KIND_TOTAL;
          tskl_q <= skl_q;
          tsku_q <= sku_q;
          tnnl_q <= nnl_q;
          tnnu_q <= nnu_q;
          tlu_q <= (nz_sum > 14'(mn)) ? (nz_sum - 14'(mn)) : 14'd0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign index_value_o = idx_q;
  assign position_o    = pos_q;
  assign last_of_run_o = last_q;
  assign skeleton_l_o  = tskl_q;
  assign skeleton_u_o  = tsku_q;
  assign nonzeros_l_o  = tnnl_q;
  assign nonzeros_u_o  = tnnu_q;
  assign nonzeros_lu_o = tlu_q;

endmodule

`default_nettype wire

### hw/rtl/ilu0_symbolic_structure_unit.sv
// ILU(0) symbolic structure unit for matrices of up to 64 by 64.
// Items arrive on in_i as transactions: begin column, row entry, end column and
// finish. Results leave on res_o: an end column yields one per U segment and one
// per L row, a finish yields one, and the final one of each input item is flagged
// by last_of_run. Configuration transactions on cfg_i are always accepted and
// must be issued only while the unit is idle.
// One item is processed at a time. An entry for a row below the supernode start
// row passes through three lookup memories; one at or above it does not.
// In an end column every U index needs a registered read of the segment memory;
// the first column of a supernode then emits one L result per L row.
// A finish yields one totals or error result.
// Results pass through a single output register; while the receiver stalls the
// unit holds at its next result and stops taking input.
// Reset clears the structure and counters and sets 64 rows and 64 columns with
// fill level zero; no clearing pass is needed.
`default_nettype none

module ilu0_symbolic_structure_unit
  import ilu_pkg::*;
(
  input  wire    clk_i,
  input  wire    rst_ni,
  ilu_in_if.sink    in_i,
  ilu_out_if.source res_o,
  ilu_cfg_if.sink   cfg_i
);

  status_t status;
  cmd_e    cmd;
  logic    in_ready;
  logic    accept;

  assign in_i.ready  = in_ready;
  assign accept      = in_i.valid && in_ready;
  assign cfg_i.ready = 1'b1;

  ilu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  ilu_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .op_i          (in_i.operation),
    .starts_i      (in_i.starts_supernode),
    .row_i         (in_i.row_index),
    .cfg_we_i      (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (res_o.ready),
    .out_valid_o   (res_o.valid),
    .kind_o        (res_o.kind),
    .index_value_o (res_o.index_value),
    .position_o    (res_o.position),
    .last_of_run_o (res_o.last_of_run),
    .skeleton_l_o  (res_o.skeleton_l),
    .skeleton_u_o  (res_o.skeleton_u),
    .nonzeros_l_o  (res_o.nonzeros_l),
    .nonzeros_u_o  (res_o.nonzeros_u),
    .nonzeros_lu_o (res_o.nonzeros_lu)
  );

endmodule

`default_nettype wire
